FILE: hdl/assert_macros.svh
// Assertion macros shared by the block dot product RTL.
// Included by the modules that check their own pipeline behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Q8_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define Q8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/q8bdp_pkg.sv
// Package for the Q8_0 block dot product: widths, block geometry, control struct.
// No dependencies; every RTL module of the block refers to it by scoped names.
package q8bdp_pkg;

    localparam int LANES       = 4;
    localparam int BLOCK_ELEMS = 32;

    localparam int ITEMS_RAW       = BLOCK_ELEMS / LANES;
    localparam int ITEMS_PER_BLOCK = (ITEMS_RAW > 0) ? ITEMS_RAW : 1;
    localparam int CNT_W           = (ITEMS_PER_BLOCK > 1) ? $clog2(ITEMS_PER_BLOCK) : 1;

    localparam int WEIGHT_W = 8;
    localparam int ACT_W    = 16;
    localparam int PROD_W   = WEIGHT_W + ACT_W;
    localparam int SUM_W    = PROD_W + ((LANES > 1) ? $clog2(LANES) : 1);
    localparam int TOTAL_W  = 30;

    localparam int HALF_W   = 16;
    localparam int EXP_W    = 5;
    localparam int MAN_W    = 10;
    localparam int SIG_W    = MAN_W + 1;
    localparam int EXP_BIAS = 15;
    localparam int ACT_FRAC = 12;
    localparam int OUT_FRAC = 24;
    // Shift that lines up (block sum * significand) with the Q.24 output.
    localparam int ALIGN    = EXP_BIAS + MAN_W + ACT_FRAC - OUT_FRAC;

    localparam logic [EXP_W-1:0] EXP_SPECIAL = 5'h1F;
    localparam logic [EXP_W-1:0] EXP_ZERO    = 5'h00;
    localparam logic [EXP_W-1:0] EXP_ONE     = 5'h01;

    localparam int MAG_W = TOTAL_W + SIG_W + 1;
    localparam int ACC_W = 64;

    typedef struct packed {
        logic valid;
        logic close;
        logic row_end;
        logic bad;
    } ctl_t;

endpackage

FILE: hdl/q8bdp_lane.sv
// One multiply lane: int8 weight times Q3.12 activation, registered.
// Depends on q8bdp_pkg.
module q8bdp_lane (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic signed [q8bdp_pkg::WEIGHT_W-1:0] weight,
    input  logic signed [q8bdp_pkg::ACT_W-1:0]    act,
    output logic signed [q8bdp_pkg::PROD_W-1:0]   prod
);

    logic signed [q8bdp_pkg::PROD_W-1:0] prod_reg;
    logic signed [q8bdp_pkg::PROD_W-1:0] prod_next;

    assign prod_next = q8bdp_pkg::PROD_W'(weight) * q8bdp_pkg::PROD_W'(act);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/q8bdp_merge.sv
// Merge stage: sums the lane products and keeps the running block total.
// Depends on q8bdp_pkg.
module q8bdp_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic signed [q8bdp_pkg::PROD_W-1:0]   prod [q8bdp_pkg::LANES],
    input  q8bdp_pkg::ctl_t                       ctl_in,
    input  logic [q8bdp_pkg::HALF_W-1:0]          scale_in,
    output logic signed [q8bdp_pkg::TOTAL_W-1:0]  total_out,
    output logic [q8bdp_pkg::HALF_W-1:0]          scale_out,
    output q8bdp_pkg::ctl_t                       ctl_out
);

    logic signed [q8bdp_pkg::SUM_W-1:0]   lane_sum;
    logic signed [q8bdp_pkg::TOTAL_W-1:0] total_reg;
    logic signed [q8bdp_pkg::TOTAL_W-1:0] total_next;
    logic signed [q8bdp_pkg::TOTAL_W-1:0] closed_reg;
    logic [q8bdp_pkg::HALF_W-1:0]         scale_reg;
    q8bdp_pkg::ctl_t                      ctl_reg;

    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < q8bdp_pkg::LANES; i++)
        begin
            lane_sum = lane_sum + q8bdp_pkg::SUM_W'(prod[i]);
        end
    end

    // Block total wraps in its own width.
    assign total_next = total_reg + q8bdp_pkg::TOTAL_W'(lane_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            ctl_reg   <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
            if (ctl_in.valid)
            begin
                total_reg <= ctl_in.close ? '0 : total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            closed_reg <= total_next;
            scale_reg  <= scale_in;
        end
    end

    assign total_out = closed_reg;
    assign scale_out = scale_reg;
    assign ctl_out   = ctl_reg;

endmodule

FILE: hdl/q8bdp_scale.sv
// Scale stages: block total times half significand, then exponent shift with rounding.
// Depends on q8bdp_pkg.
module q8bdp_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic signed [q8bdp_pkg::TOTAL_W-1:0] total,
    input  logic [q8bdp_pkg::HALF_W-1:0]         scale,
    input  q8bdp_pkg::ctl_t                      ctl_in,
    output logic signed [q8bdp_pkg::ACC_W-1:0]   term,
    output q8bdp_pkg::ctl_t                      ctl_out
);

    logic [q8bdp_pkg::EXP_W-1:0]         exp_field;
    logic [q8bdp_pkg::EXP_W-1:0]         exp_eff;
    logic [q8bdp_pkg::SIG_W-1:0]         sig;
    logic signed [q8bdp_pkg::MAG_W-1:0]  prod;
    logic signed [q8bdp_pkg::MAG_W-1:0]  mag_next;

    logic signed [q8bdp_pkg::MAG_W-1:0]  mag_reg;
    logic [q8bdp_pkg::EXP_W-1:0]         exp_reg;
    q8bdp_pkg::ctl_t                     ctl3_reg;
    q8bdp_pkg::ctl_t                     ctl3_next;

    logic signed [q8bdp_pkg::ACC_W-1:0]  mag_wide;
    logic signed [q8bdp_pkg::ACC_W-1:0]  half;
    logic [q8bdp_pkg::EXP_W-1:0]         up_sh;
    logic [q8bdp_pkg::EXP_W-1:0]         dn_sh;
    logic signed [q8bdp_pkg::ACC_W-1:0]  term_next;
    logic signed [q8bdp_pkg::ACC_W-1:0]  term_reg;
    q8bdp_pkg::ctl_t                     ctl4_reg;

    // Multiply stage; subnormals drop the hidden bit and use the lowest exponent.
    assign exp_field = scale[q8bdp_pkg::MAN_W +: q8bdp_pkg::EXP_W];

    always_comb
    begin
        if (exp_field == q8bdp_pkg::EXP_ZERO)
        begin
            sig     = {1'b0, scale[q8bdp_pkg::MAN_W-1:0]};
            exp_eff = q8bdp_pkg::EXP_ONE;
        end
        else
        begin
            sig     = {1'b1, scale[q8bdp_pkg::MAN_W-1:0]};
            exp_eff = exp_field;
        end
    end

    assign prod     = q8bdp_pkg::MAG_W'(total) * q8bdp_pkg::MAG_W'($signed({1'b0, sig}));
    assign mag_next = scale[q8bdp_pkg::HALF_W-1] ? -prod : prod;

    always_comb
    begin
        ctl3_next     = ctl_in;
        ctl3_next.bad = (exp_field == q8bdp_pkg::EXP_SPECIAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (adv)
        begin
            ctl3_reg <= ctl3_next;
            ctl4_reg <= ctl3_reg;
        end
    end

    // Shift stage: left for large exponents, else round half up and shift right.
    assign mag_wide = q8bdp_pkg::ACC_W'(mag_reg);
    assign up_sh    = exp_reg - q8bdp_pkg::EXP_W'(q8bdp_pkg::ALIGN);
    assign dn_sh    = q8bdp_pkg::EXP_W'(q8bdp_pkg::ALIGN) - exp_reg;
    assign half     = q8bdp_pkg::ACC_W'(1) <<< (dn_sh - q8bdp_pkg::EXP_W'(1));

    always_comb
    begin
        if (exp_reg >= q8bdp_pkg::EXP_W'(q8bdp_pkg::ALIGN))
        begin
            term_next = mag_wide <<< up_sh;
        end
        else
        begin
            term_next = (mag_wide + half) >>> dn_sh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg  <= mag_next;
            exp_reg  <= exp_eff;
            term_reg <= term_next;
        end
    end

    assign term    = term_reg;
    assign ctl_out = ctl4_reg;

endmodule

FILE: hdl/q8bdp_accum.sv
// Row accumulator with saturation, sticky flags and the result register.
// Depends on q8bdp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module q8bdp_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic signed [q8bdp_pkg::ACC_W-1:0]  term,
    input  q8bdp_pkg::ctl_t                     ctl_in,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [q8bdp_pkg::ACC_W-1:0]  row_sum,
    output logic                                saturated,
    output logic                                bad_scale
);

    localparam logic signed [q8bdp_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(q8bdp_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [q8bdp_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(q8bdp_pkg::ACC_W-1){1'b0}}};

    logic signed [q8bdp_pkg::ACC_W-1:0] acc_reg;
    logic signed [q8bdp_pkg::ACC_W-1:0] acc_next;
    logic signed [q8bdp_pkg::ACC_W-1:0] raw_sum;
    logic                               clip_reg;
    logic                               clip_next;
    logic                               bad_reg;
    logic                               bad_next;
    logic                               ovf;
    logic                               add_en;
    logic                               emit;

    logic                               out_valid_reg;
    logic signed [q8bdp_pkg::ACC_W-1:0] row_sum_reg;
    logic                               saturated_reg;
    logic                               bad_scale_reg;

    assign add_en  = ctl_in.valid && ctl_in.close && !ctl_in.bad;
    assign emit    = adv && ctl_in.valid && ctl_in.row_end;
    assign raw_sum = acc_reg + term;
    assign ovf     = (acc_reg[q8bdp_pkg::ACC_W-1] == term[q8bdp_pkg::ACC_W-1])
                  && (raw_sum[q8bdp_pkg::ACC_W-1] != acc_reg[q8bdp_pkg::ACC_W-1]);

    always_comb
    begin
        acc_next  = acc_reg;
        clip_next = clip_reg;
        bad_next  = bad_reg;
        if (ctl_in.valid && ctl_in.close && ctl_in.bad)
        begin
            bad_next = 1'b1;
        end
        if (add_en)
        begin
            if (ovf)
            begin
                acc_next  = acc_reg[q8bdp_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX;
                clip_next = 1'b1;
            end
            else
            begin
                acc_next = raw_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                if (emit)
                begin
                    // Drop row state once the result is captured.
                    acc_reg       <= '0;
                    clip_reg      <= 1'b0;
                    bad_reg       <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    clip_reg <= clip_next;
                    bad_reg  <= bad_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_sum_reg   <= acc_next;
            saturated_reg <= clip_next;
            bad_scale_reg <= bad_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_sum   = row_sum_reg;
    assign saturated = saturated_reg;
    assign bad_scale = bad_scale_reg;

    `Q8_ASSERT_NEXT(a_row_clears, clk, rst_n, emit, (acc_reg == '0) && !clip_reg && !bad_reg, "row state not cleared after emit")
    `Q8_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !emit, "pending result overwritten")

endmodule

FILE: hdl/q8_block_dot_product.sv
// Q8_0 block dot product: one output of a quantized matrix-vector product.
// Depends on q8bdp_pkg, q8bdp_lane, q8bdp_merge, q8bdp_scale, q8bdp_accum, assert_macros.svh.
//
// The block takes one transaction per clock: four int8 weights, four Q3.12
// activations, a half-precision block scale and a row-end mark. The scale is
// sampled on the first transaction of each 32-element block (eight
// transactions) and ignored on the others. Four lane multipliers work side by
// side, a merge stage sums them into the block total, and at block end (or at
// row end, which closes a partial block) the total is multiplied by the scale
// significand, shifted by its exponent with round-half-up, and added into a
// saturating 64-bit Q.24 row accumulator. An infinite or NaN scale adds
// nothing and sets bad_scale. On the row-end transaction one result is
// delivered: row_sum, saturated and bad_scale, and row state is cleared.
// Throughput is one transaction per cycle while in_ready is high. A result
// reaches the output register through the stages in order: the edge that
// accepts its row-end transaction loads the lane multiply stage, then merge,
// scale multiply, shift and accumulate follow, the last loading the output
// register. The output register lets accepted transactions keep flowing while
// a result waits; in_ready drops only when a row result reaches the
// accumulator while the previous result has not yet been taken.
`include "assert_macros.svh"

module q8_block_dot_product (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [q8bdp_pkg::HALF_W-1:0]           scale_half,
    input  logic signed [q8bdp_pkg::WEIGHT_W-1:0]  weight_a,
    input  logic signed [q8bdp_pkg::WEIGHT_W-1:0]  weight_b,
    input  logic signed [q8bdp_pkg::WEIGHT_W-1:0]  weight_c,
    input  logic signed [q8bdp_pkg::WEIGHT_W-1:0]  weight_d,
    input  logic signed [q8bdp_pkg::ACT_W-1:0]     act_a,
    input  logic signed [q8bdp_pkg::ACT_W-1:0]     act_b,
    input  logic signed [q8bdp_pkg::ACT_W-1:0]     act_c,
    input  logic signed [q8bdp_pkg::ACT_W-1:0]     act_d,
    input  logic                                   row_end,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [q8bdp_pkg::ACC_W-1:0]     row_sum,
    output logic                                   saturated,
    output logic                                   bad_scale
);

    logic signed [q8bdp_pkg::WEIGHT_W-1:0] weights [q8bdp_pkg::LANES];
    logic signed [q8bdp_pkg::ACT_W-1:0]    acts    [q8bdp_pkg::LANES];
    logic signed [q8bdp_pkg::PROD_W-1:0]   prods   [q8bdp_pkg::LANES];

    logic                                  adv;
    logic                                  accept;
    logic                                  last_in_block;
    logic                                  close_in;

    // Block position and the scale held for the block.
    logic [q8bdp_pkg::CNT_W-1:0]           cnt_reg;
    logic [q8bdp_pkg::CNT_W-1:0]           cnt_next;
    logic [q8bdp_pkg::HALF_W-1:0]          held_scale_reg;
    logic [q8bdp_pkg::HALF_W-1:0]          scale_sel;

    // Stage 1 side-band beside the lane products.
    q8bdp_pkg::ctl_t                       ctl1_reg;
    q8bdp_pkg::ctl_t                       ctl1_next;
    logic [q8bdp_pkg::HALF_W-1:0]          scale1_reg;

    q8bdp_pkg::ctl_t                       ctl2;
    logic signed [q8bdp_pkg::TOTAL_W-1:0]  total2;
    logic [q8bdp_pkg::HALF_W-1:0]          scale2;
    q8bdp_pkg::ctl_t                       ctl4;
    logic signed [q8bdp_pkg::ACC_W-1:0]    term4;

    assign weights[0] = weight_a;
    assign weights[1] = weight_b;
    assign weights[2] = weight_c;
    assign weights[3] = weight_d;
    assign acts[0]    = act_a;
    assign acts[1]    = act_b;
    assign acts[2]    = act_c;
    assign acts[3]    = act_d;

    // Hold the whole pipeline only when a row result would land on an untaken one.
    assign adv      = !(ctl4.valid && ctl4.row_end && out_valid && !out_ready);
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    assign last_in_block = (cnt_reg == q8bdp_pkg::CNT_W'(q8bdp_pkg::ITEMS_PER_BLOCK - 1));
    assign close_in      = last_in_block || row_end;
    assign scale_sel     = (cnt_reg == '0) ? scale_half : held_scale_reg;
    assign cnt_next      = close_in ? '0 : cnt_reg + q8bdp_pkg::CNT_W'(1);

    always_comb
    begin
        ctl1_next         = '0;
        ctl1_next.valid   = in_valid;
        ctl1_next.close   = close_in;
        ctl1_next.row_end = row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            held_scale_reg <= '0;
            ctl1_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg        <= cnt_next;
                held_scale_reg <= scale_sel;
            end
            if (adv)
            begin
                ctl1_reg <= ctl1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scale1_reg <= scale_sel;
        end
    end

    for (genvar g = 0; g < q8bdp_pkg::LANES; g++)
    begin : g_lane
        q8bdp_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .weight (weights[g]),
            .act    (acts[g]),
            .prod   (prods[g])
        );
    end

    q8bdp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .prod      (prods),
        .ctl_in    (ctl1_reg),
        .scale_in  (scale1_reg),
        .total_out (total2),
        .scale_out (scale2),
        .ctl_out   (ctl2)
    );

    q8bdp_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .total   (total2),
        .scale   (scale2),
        .ctl_in  (ctl2),
        .term    (term4),
        .ctl_out (ctl4)
    );

    q8bdp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .term      (term4),
        .ctl_in    (ctl4),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .row_sum   (row_sum),
        .saturated (saturated),
        .bad_scale (bad_scale)
    );

    `Q8_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= q8bdp_pkg::CNT_W'(q8bdp_pkg::ITEMS_PER_BLOCK - 1), "block position out of range")
    `Q8_ASSERT_NEXT(a_row_restarts_block, clk, rst_n, accept && row_end, cnt_reg == '0, "row end did not restart the block")

endmodule

FILE: bench/tb.sv
// Self-checking bench for q8_block_dot_product: quantized block dot products
// checked against an in-bench predictor of the row sum and its flags.
// Depends on q8bdp_pkg and the q8_block_dot_product RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES           = q8bdp_pkg::LANES;
    localparam int ITEMS_PER_BLOCK = q8bdp_pkg::ITEMS_PER_BLOCK;
    localparam int WEIGHT_W        = q8bdp_pkg::WEIGHT_W;
    localparam int ACT_W           = q8bdp_pkg::ACT_W;
    localparam int TOTAL_W         = q8bdp_pkg::TOTAL_W;
    localparam int HALF_W          = q8bdp_pkg::HALF_W;
    localparam int EXP_W           = q8bdp_pkg::EXP_W;
    localparam int MAN_W           = q8bdp_pkg::MAN_W;
    localparam int ALIGN           = q8bdp_pkg::ALIGN;
    localparam int ACC_W           = q8bdp_pkg::ACC_W;
    localparam logic [EXP_W-1:0] EXP_SPECIAL = q8bdp_pkg::EXP_SPECIAL;
    localparam logic [EXP_W-1:0] EXP_ZERO    = q8bdp_pkg::EXP_ZERO;
    localparam logic [EXP_W-1:0] EXP_ONE     = q8bdp_pkg::EXP_ONE;

    // Run length guard, far above the slowest legal run (saturation rows,
    // long sender gaps, receiver stalls on every row).
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Cycles to wait after the last expected row so a stray result shows up.
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 400;
    localparam int SAT_BLOCKS = 264;

    typedef struct {
        logic [HALF_W-1:0]          scale;
        logic signed [WEIGHT_W-1:0] w [LANES];
        logic signed [ACT_W-1:0]    a [LANES];
        logic                       last;
    } lane_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] total;
        logic                    clip;
        logic                    bad;
    } row_result_t;

    typedef struct {
        lane_item_t  it;
        bit          typed;
        row_result_t want;
    } table_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [HALF_W-1:0] scale_half = '0;
    logic signed [WEIGHT_W-1:0] weight_a = '0;
    logic signed [WEIGHT_W-1:0] weight_b = '0;
    logic signed [WEIGHT_W-1:0] weight_c = '0;
    logic signed [WEIGHT_W-1:0] weight_d = '0;
    logic signed [ACT_W-1:0] act_a = '0;
    logic signed [ACT_W-1:0] act_b = '0;
    logic signed [ACT_W-1:0] act_c = '0;
    logic signed [ACT_W-1:0] act_d = '0;
    logic row_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [ACC_W-1:0] row_sum;
    logic saturated;
    logic bad_scale;

    // Rows whose result is still owed by the block, oldest first.
    row_result_t pending_rows[$];
    table_row_t  stim_table[$];

    // Predictor state: running block sum, position in block, sampled scale,
    // row accumulator and the sticky row flags.
    logic signed [TOTAL_W-1:0] blk_total = '0;
    int unsigned               blk_pos = 0;
    logic [HALF_W-1:0]         blk_scale = '0;
    logic signed [ACC_W-1:0]   row_acc = '0;
    bit                        row_clip = 1'b0;
    bit                        row_bad = 1'b0;

    bit burst = 1'b0;           // sender offers back to back while set
    bit stall_request = 1'b0;   // ask the receiver for one long hold-off
    bit stall_done = 1'b0;
    int mismatches = 0;
    int unsigned cycle_count = 0;

    q8_block_dot_product uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scale_half (scale_half),
        .weight_a   (weight_a),
        .weight_b   (weight_b),
        .weight_c   (weight_c),
        .weight_d   (weight_d),
        .act_a      (act_a),
        .act_b      (act_b),
        .act_c      (act_c),
        .act_d      (act_d),
        .row_end    (row_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_sum    (row_sum),
        .saturated  (saturated),
        .bad_scale  (bad_scale)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Print one line per mismatch (the first few dozen) and count all of them.
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < 40)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Advance the predictor by one accepted transaction. Close the block on its
    // eighth item or on row end; on row end hand back the row result and clear.
    task automatic predict_item(input lane_item_t it, output bit done,
                                output row_result_t res);
        longint prod;
        longint sig;
        longint mag;
        longint term;
        longint s;
        logic [EXP_W-1:0] ex;
        int sh;
        int i;
        if (blk_pos == 0)
            blk_scale = it.scale;
        for (i = 0; i < LANES; i++)
        begin
            prod = longint'(it.w[i]) * longint'(it.a[i]);
            blk_total = blk_total + TOTAL_W'(prod);
        end
        if (blk_pos + 1 >= ITEMS_PER_BLOCK || it.last)
        begin
            ex = blk_scale[MAN_W +: EXP_W];
            if (ex == EXP_SPECIAL)
                row_bad = 1'b1;
            else
            begin
                // Subnormal and zero: no hidden bit, exponent taken as one.
                if (ex == EXP_ZERO)
                begin
                    sig = longint'(blk_scale[MAN_W-1:0]);
                    ex = EXP_ONE;
                end
                else
                    sig = longint'({1'b1, blk_scale[MAN_W-1:0]});
                mag = longint'(blk_total) * sig;
                if (blk_scale[HALF_W-1])
                    mag = -mag;
                sh = int'(ex) - ALIGN;
                // Right shifts round half up: add half, then floor.
                if (sh >= 0)
                    term = mag <<< sh;
                else
                    term = (mag + (longint'(1) <<< (-sh - 1))) >>> (-sh);
                s = row_acc + term;
                if (row_acc[ACC_W-1] == term[63] && s[63] != row_acc[ACC_W-1])
                begin
                    s = row_acc[ACC_W-1] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
                    row_clip = 1'b1;
                end
                row_acc = s;
            end
            blk_total = '0;
            blk_pos = 0;
        end
        else
            blk_pos++;
        done = it.last;
        res = '0;
        if (it.last)
        begin
            res.total = row_acc;
            res.clip = row_clip;
            res.bad = row_bad;
            row_acc = '0;
            row_clip = 1'b0;
            row_bad = 1'b0;
            blk_scale = '0;
        end
    endtask

    // Lane 0 sits in the low bits of wv and av.
    function automatic lane_item_t make_item(input logic [HALF_W-1:0] scale,
                                             input logic [4*WEIGHT_W-1:0] wv,
                                             input logic [4*ACT_W-1:0] av,
                                             input bit last);
        lane_item_t it;
        int i;
        it.scale = scale;
        for (i = 0; i < LANES; i++)
        begin
            it.w[i] = wv[WEIGHT_W*i +: WEIGHT_W];
            it.a[i] = av[ACT_W*i +: ACT_W];
        end
        it.last = last;
        return it;
    endfunction

    task automatic add_row(input logic [HALF_W-1:0] scale, input logic [4*WEIGHT_W-1:0] wv,
                           input logic [4*ACT_W-1:0] av, input bit last,
                           input bit typed = 1'b0, input longint want_sum = 0,
                           input bit want_sat = 1'b0, input bit want_bad = 1'b0);
        table_row_t r;
        r.it = make_item(scale, wv, av, last);
        r.typed = typed;
        r.want.total = want_sum;
        r.want.clip = want_sat;
        r.want.bad = want_bad;
        stim_table.insert(stim_table.size(), r);
    endtask

    // Random transaction: scale exponent biased toward useful ranges with
    // zero, subnormal, special and top exponents mixed in; lanes full range
    // with extremes sprinkled in.
    function automatic lane_item_t random_item(input bit last);
        lane_item_t it;
        int pick;
        int i;
        pick = $urandom_range(0, 99);
        it.scale = HALF_W'($urandom);
        if (pick < 50)
            it.scale[MAN_W +: EXP_W] = EXP_W'($urandom_range(8, 20));
        else if (pick < 60)
            it.scale[MAN_W +: EXP_W] = EXP_ZERO;
        else if (pick < 65)
            it.scale[MAN_W +: EXP_W] = EXP_SPECIAL;
        else if (pick < 75)
            it.scale[MAN_W +: EXP_W] = 5'd30;
        for (i = 0; i < LANES; i++)
        begin
            it.w[i] = WEIGHT_W'($urandom);
            it.a[i] = ACT_W'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        it.w[i] = 8'sh80;
                        it.a[i] = 16'sh8000;
                    end
                    1:
                    begin
                        it.w[i] = 8'sh7F;
                        it.a[i] = 16'sh7FFF;
                    end
                    2:
                    begin
                        it.w[i] = '0;
                        it.a[i] = '0;
                    end
                    default:
                    begin
                        it.w[i] = '1;
                        it.a[i] = '1;
                    end
                endcase
            end
        end
        it.last = last;
        return it;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one transaction and hold it until accepted. Entered and left at a
    // rising edge; valid and payload change only at rising edges.
    task automatic offer(input lane_item_t it, input bit typed, input row_result_t want);
        int gap;
        bit done;
        row_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        scale_half <= it.scale;
        weight_a <= it.w[0];
        weight_b <= it.w[1];
        weight_c <= it.w[2];
        weight_d <= it.w[3];
        act_a <= it.a[0];
        act_b <= it.a[1];
        act_c <= it.a[2];
        act_d <= it.a[3];
        row_end <= it.last;
        // Sample the handshake mid-cycle; the transaction lands on the next edge.
        do
            @(negedge clk);
        while (!in_ready);
        predict_item(it, done, res);
        if (done)
            pending_rows.insert(pending_rows.size(), typed ? want : res);
        @(posedge clk);
    endtask

    // Drop valid and wait until every owed row has come back, then a little more.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Random rows: mostly short (partial blocks), some spanning many blocks.
    task automatic random_rows(input int n_items);
        int sent;
        int len;
        int r;
        int j;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                len = $urandom_range(1, 8);
            else if (r < 80)
                len = $urandom_range(9, 24);
            else if (r < 95)
                len = $urandom_range(25, 64);
            else
                len = $urandom_range(65, 160);
            burst = ($urandom_range(0, 3) == 0);
            for (j = 0; j < len; j++)
                offer(random_item(j == len - 1), 1'b0, '0);
            sent += len;
        end
        burst = 1'b0;
    endtask

    // Receiver: segments of always-ready, mostly-ready, mostly-stalled and
    // fully stalled; one long hold-off on request so the block backs up.
    initial
    begin : receiver
        int seg_left;
        int seg_kind;
        int hold_left;
        seg_left = 0;
        seg_kind = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_request && !stall_done)
            begin
                stall_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_kind = $urandom_range(0, 9);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                if (seg_kind < 4)
                    out_ready <= 1'b1;
                else if (seg_kind < 7)
                    out_ready <= ($urandom_range(0, 3) != 0);
                else if (seg_kind < 9)
                    out_ready <= ($urandom_range(0, 3) == 0);
                else
                    out_ready <= 1'b0;
            end
        end
    end

    // Result checker: compare each accepted result against the oldest owed row.
    initial
    begin : row_checker
        row_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_rows.size() == 0)
                    flag_mismatch("unexpected result", row_sum, '0);
                else
                begin
                    want = pending_rows.pop_front();
                    if (row_sum !== want.total)
                        flag_mismatch("row_sum", row_sum, want.total);
                    if (saturated !== want.clip)
                        flag_mismatch("saturated", 64'(saturated), 64'(want.clip));
                    if (bad_scale !== want.bad)
                        flag_mismatch("bad_scale", 64'(bad_scale), 64'(want.bad));
                end
            end
        end
    end

    // Hang guard: end the run if it goes far past any legal length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        int b;
        int j;

        // Directed table. Typed rows carry values readable straight off the
        // format; the rest are checked against the predictor.
        add_row(16'h3C00, '0, '0, 1'b1, 1'b1, 0, 1'b0, 1'b0);
        add_row(16'h3C00, {4{8'h01}}, {4{16'h1000}}, 1'b1, 1'b1, 64'sd67108864, 1'b0, 1'b0);
        add_row(16'h3C00, {4{8'h80}}, {4{16'h8000}}, 1'b1, 1'b1, 64'sd68719476736, 1'b0, 1'b0);
        add_row(16'h3C00, {4{8'h7F}}, {4{16'h8000}}, 1'b1);
        add_row(16'h7BFF, {4{8'h80}}, {4{16'h7FFF}}, 1'b1);
        // Infinite and NaN scales add nothing and raise the flag.
        add_row(16'h7C00, {4{8'h7F}}, {4{16'h7FFF}}, 1'b1, 1'b1, 0, 1'b0, 1'b1);
        add_row(16'hFE00, {8'h7F, 8'h80, 8'hFF, 8'h01}, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h1234},
                1'b1, 1'b1, 0, 1'b0, 1'b1);
        // Positive and negative zero scale.
        add_row(16'h0000, {4{8'h7F}}, {4{16'h7FFF}}, 1'b1, 1'b1, 0, 1'b0, 1'b0);
        add_row(16'h8000, {4{8'h80}}, {4{16'h8000}}, 1'b1, 1'b1, 0, 1'b0, 1'b0);
        // Subnormals and the smallest normal.
        add_row(16'h0001, {4{8'h80}}, {4{16'h8000}}, 1'b1);
        add_row(16'h83FF, {4{8'h7F}}, {4{16'h7FFF}}, 1'b1);
        add_row(16'h0400, {4{8'h80}}, {4{16'h7FFF}}, 1'b1);
        // Rounding: exact half rounds up, negative half rounds to zero, below half drops.
        add_row(16'h0400, {8'h00, 8'h00, 8'h01, 8'h01}, {16'h0, 16'h0, 16'h1, 16'h1}, 1'b1);
        add_row(16'h0400, {8'h00, 8'h00, 8'hFF, 8'hFF}, {16'h0, 16'h0, 16'h1, 16'h1}, 1'b1);
        add_row(16'h0400, {4{8'h01}}, {16'h0, 16'h0, 16'h0, 16'h1}, 1'b1);
        // One full block then a partial block closed by row end. Scales on the
        // inner items are infinite and must be ignored.
        for (j = 0; j < 9; j++)
            add_row(j == 0 ? 16'h3C00 : (j == 8 ? 16'hC000 : 16'h7C00),
                    {8'h05, 8'hFB, 8'h40, 8'hC0}, {16'h0800, 16'h1800, 16'hF000, 16'h7FFF},
                    j == 8);

        // Hold reset, then release it on a rising edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < stim_table.size(); k++)
            offer(stim_table[k].it, stim_table[k].typed, stim_table[k].want);
        drain();

        // Saturation: ramp to the positive limit, then pull back with one
        // negative block in the same row so the clip flag must stay set.
        for (b = 0; b < SAT_BLOCKS; b++)
            for (j = 0; j < ITEMS_PER_BLOCK; j++)
                offer(make_item(16'h7BFF, {4{8'h80}}, {4{16'h8000}}, 1'b0), 1'b0, '0);
        for (j = 0; j < ITEMS_PER_BLOCK; j++)
            offer(make_item(16'hFBFF, {4{8'h80}}, {4{16'h8000}}, j == ITEMS_PER_BLOCK - 1),
                  1'b0, '0);
        drain();

        random_rows(RANDOM_ITEMS / 2);
        // Pause the sender until every owed row is back.
        drain();

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering one-transaction rows back to back.
        stall_request = 1'b1;
        burst = 1'b1;
        for (j = 0; j < 60; j++)
            offer(random_item(1'b1), 1'b0, '0);
        burst = 1'b0;

        random_rows(RANDOM_ITEMS / 2);
        drain();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/q8bdp_pkg.sv
hdl/q8bdp_lane.sv
hdl/q8bdp_merge.sv
hdl/q8bdp_scale.sv
hdl/q8bdp_accum.sv
hdl/q8_block_dot_product.sv
bench/tb.sv
